// ===== sv/apm_pkg.sv =====
// Shared types and constants for the analogue input to PWM slot mapper.
package apm_pkg;

	// Field widths fixed by the interface.
	localparam int SAMPLE_W   = 12;
	localparam int CH_N       = 8;
	localparam int VAL_W      = 8;
	localparam int IDX_W      = 4;
	localparam int OFF_W      = 5;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 48;
	localparam int TICKS_W    = 16;
	localparam int THR_W      = 14;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_TYPES      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NULLS_LO   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NULLS_HI   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BATT_MIN   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BATT_MAX   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_POWER_ON   = 3'd5;

	// Request codes.
	localparam logic REQ_SCAN = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	// Channel type codes; the remaining codes mean unused.
	localparam logic [1:0] TYPE_POT = 2'd1;
	localparam logic [1:0] TYPE_JOY = 2'd2;

	// Saturation limits and the full-scale duty.
	localparam logic [SAMPLE_W-1:0] POT_LIMIT = 12'd4080;
	localparam logic [SAMPLE_W-1:0] JOY_LIMIT = 12'd2040;
	localparam logic [VAL_W-1:0]    DUTY_FULL = 8'hff;

	// Divide by ten as a multiply by 3277 / 2**15, exact for 12-bit values.
	localparam logic [11:0] RECIP_TEN   = 12'd3277;
	localparam int          RECIP_SHIFT = 15;

	// What one channel lane produces: slots used and the two slot values.
	typedef struct packed {
		logic [1:0]       used;
		logic [VAL_W-1:0] val_a;
		logic [VAL_W-1:0] val_b;
	} lane_res_t;

endpackage

// ===== sv/apm_lane.sv =====
// One channel lane: turns a sample and its null into up to two slot duties.
module apm_lane (
	input  logic [apm_pkg::SAMPLE_W-1:0] sample,
	input  logic [apm_pkg::SAMPLE_W-1:0] null_pos,
	input  logic [1:0]                   ctype,
	output apm_pkg::lane_res_t           res
);
	import apm_pkg::*;

	logic                ge;
	logic                gt;
	logic [SAMPLE_W-1:0] mag;
	logic [VAL_W-1:0]    pot_val;
	logic [VAL_W-1:0]    joy_val;

	// Deflection from the null in either direction.
	assign ge  = sample >= null_pos;
	assign gt  = sample > null_pos;
	assign mag = ge ? (sample - null_pos) : (null_pos - sample);

	// Scaled and saturated duties for the two channel kinds.
	assign pot_val = (mag > POT_LIMIT) ? DUTY_FULL : mag[11:4];
	assign joy_val = (mag > JOY_LIMIT) ? DUTY_FULL : mag[10:3];

	// Select by channel type; a joystick drives only the slot on its side.
	always_comb begin
		res = '0;
		case (ctype)
			TYPE_POT: begin
				res.used  = 2'd1;
				res.val_a = ge ? pot_val : '0;
			end
			TYPE_JOY: begin
				res.used = 2'd2;
				if (gt) begin
					res.val_a = joy_val;
				end else if (!ge) begin
					res.val_b = joy_val;
				end
			end
			default: begin
				res = '0;
			end
		endcase
	end

endmodule

// ===== sv/apm_merge.sv =====
// Merging stage: packs the lane results into consecutive slots and blanks them.
module apm_merge #(
	parameter int SLOT_COUNT = 16
) (
	input  apm_pkg::lane_res_t [apm_pkg::CH_N-1:0]    lanes,
	input  logic                                      blank,
	output logic [SLOT_COUNT-1:0][apm_pkg::VAL_W-1:0] slots
);
	import apm_pkg::*;

	logic [CH_N-1:0][OFF_W-1:0] offs;

	// First slot of each channel is the running count of slots used before it.
	always_comb begin
		offs[0] = '0;
		for (int c = 1; c < CH_N; c++) begin
			offs[c] = offs[c-1] + OFF_W'(lanes[c-1].used);
		end
	end

	// Each slot takes the value of the lane whose first or second slot it is.
	always_comb begin
		slots = '0;
		for (int k = 0; k < SLOT_COUNT; k++) begin
			for (int c = 0; c < CH_N; c++) begin
				if (lanes[c].used != 2'd0 && offs[c] == OFF_W'(k)) begin
					slots[k] = lanes[c].val_a;
				end
				if (lanes[c].used == 2'd2 && offs[c] + OFF_W'(1) == OFF_W'(k)) begin
					slots[k] = lanes[c].val_b;
				end
			end
			if (blank) begin
				slots[k] = '0;
			end
		end
	end

endmodule

// ===== sv/analog_input_to_pwm_mapper_top.sv =====
// Top level of the analogue input to PWM slot mapper: config, lanes, pipeline and emitter.
//
//  Channel  Signals                                  Direction  Moves
//  in       in_valid/in_ready, req_type, sample_0..7 in         one scan or tick item
//           battery_sample
//  out      out_valid/out_ready, slot_index,          out        one slot result item
//           slot_value, battery_low, battery_empty, last
//  cfg      cfg_valid/cfg_ready, cfg_index, cfg_data  in         one register write
//
// A scan passes an input register, eight parallel channel lanes, a lane result register
// and a merge stage before it is loaded into the slot emitter. The emitter sends SLOT_COUNT
// items, one per cycle while out_ready is high, and loads the next row as its last is taken;
// ticks only step the blanking timer and do not enter the pipeline.
// Reset clears the pipeline, the blanking timer and the registers to their defaults.
// A stall on out holds the emitter, then the stages behind it, then in_ready.
module analog_input_to_pwm_mapper_top #(
	parameter int SLOT_COUNT = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            req_type,
	input  logic [apm_pkg::SAMPLE_W-1:0]    sample_0,
	input  logic [apm_pkg::SAMPLE_W-1:0]    sample_1,
	input  logic [apm_pkg::SAMPLE_W-1:0]    sample_2,
	input  logic [apm_pkg::SAMPLE_W-1:0]    sample_3,
	input  logic [apm_pkg::SAMPLE_W-1:0]    sample_4,
	input  logic [apm_pkg::SAMPLE_W-1:0]    sample_5,
	input  logic [apm_pkg::SAMPLE_W-1:0]    sample_6,
	input  logic [apm_pkg::SAMPLE_W-1:0]    sample_7,
	input  logic [apm_pkg::SAMPLE_W-1:0]    battery_sample,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [apm_pkg::IDX_W-1:0]       slot_index,
	output logic [apm_pkg::VAL_W-1:0]       slot_value,
	output logic                            battery_low,
	output logic                            battery_empty,
	output logic                            last,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [apm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [apm_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import apm_pkg::*;

	localparam int SW = $clog2(SLOT_COUNT);

	// Configuration registers.
	logic [2*CH_N-1:0]   types_q;
	logic [47:0]         nulls_lo_q;
	logic [47:0]         nulls_hi_q;
	logic [SAMPLE_W-1:0] bmin_q;
	logic [SAMPLE_W-1:0] bmax_q;
	logic [TICKS_W-1:0]  pticks_q;

	// Power-on blanking timer.
	logic               started_q;
	logic [TICKS_W-1:0] remain_q;

	// Pipeline stages.
	logic                             valid_s1;
	logic [CH_N-1:0][SAMPLE_W-1:0]    samples_s1;
	logic [SAMPLE_W-1:0]              batt_s1;
	logic                             blank_s1;
	logic                             valid_s2;
	lane_res_t [CH_N-1:0]             lanes_s2;
	logic [SAMPLE_W-1:0]              batt_s2;
	logic                             blank_s2;
	logic signed [THR_W-1:0]          thresh_s2;

	// Emitter.
	logic                             busy_q;
	logic [SW-1:0]                    cnt_q;
	logic [SLOT_COUNT-1:0][VAL_W-1:0] slots_q;
	logic                             low_q;
	logic                             empty_q;

	logic                             in_fire;
	logic                             out_fire;
	logic                             cnt_last;
	logic                             emit_free;
	logic                             s2_move;
	logic                             s2_free;
	logic                             s1_move;
	logic                             blank_new;
	lane_res_t [CH_N-1:0]             lane_res;
	logic [SLOT_COUNT-1:0][VAL_W-1:0] merged;
	logic [CH_N-1:0][SAMPLE_W-1:0]    samples_in;
	logic [THR_W-1:0]                 band;
	logic [SAMPLE_W-1:0]              band_mag;
	logic [23:0]                      band_prod;
	logic [THR_W-1:0]                 tenth;
	logic [THR_W-1:0]                 thresh;

	assign samples_in = {sample_7, sample_6, sample_5, sample_4,
			sample_3, sample_2, sample_1, sample_0};

	// Handshake chain from the emitter back to the input.
	assign cnt_last  = cnt_q == SW'(SLOT_COUNT - 1);
	assign out_fire  = out_valid && out_ready;
	assign emit_free = !busy_q || (out_fire && cnt_last);
	assign s2_move   = valid_s2 && emit_free;
	assign s2_free   = !valid_s2 || s2_move;
	assign s1_move   = valid_s1 && s2_free;
	assign in_ready  = !valid_s1 || s1_move;
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// Configuration writes; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			types_q    <= '0;
			nulls_lo_q <= '0;
			nulls_hi_q <= '0;
			bmin_q     <= '0;
			bmax_q     <= '1;
			pticks_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_TYPES:    types_q    <= cfg_data[2*CH_N-1:0];
				REG_NULLS_LO: nulls_lo_q <= cfg_data[47:0];
				REG_NULLS_HI: nulls_hi_q <= cfg_data[47:0];
				REG_BATT_MIN: bmin_q     <= cfg_data[SAMPLE_W-1:0];
				REG_BATT_MAX: bmax_q     <= cfg_data[SAMPLE_W-1:0];
				REG_POWER_ON: pticks_q   <= cfg_data[TICKS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Blanking applies if the timer, loaded on the first scan, is still running.
	assign blank_new = started_q ? (remain_q != '0) : (pticks_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			remain_q  <= '0;
		end else if (in_fire) begin
			if (req_type == REQ_TICK) begin
				if (remain_q != '0) begin
					remain_q <= remain_q - TICKS_W'(1);
				end
			end else if (!started_q) begin
				started_q <= 1'b1;
				remain_q  <= pticks_q;
			end
		end
	end

	// Input register; only scan items enter the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_fire && (req_type == REQ_SCAN);
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			samples_s1 <= samples_in;
			batt_s1    <= battery_sample;
			blank_s1   <= blank_new;
		end
	end

	// Channel lanes working side by side.
	for (genvar c = 0; c < CH_N; c++) begin : g_lane
		apm_lane u_lane (
			.sample   (samples_s1[c]),
			.null_pos (c < 4 ? nulls_lo_q[12*(c%4) +: 12] : nulls_hi_q[12*(c%4) +: 12]),
			.ctype    (types_q[2*c +: 2]),
			.res      (lane_res[c])
		);
	end

	// Low battery threshold: min plus a tenth of the band, truncated toward zero.
	assign band      = {2'b00, bmax_q} - {2'b00, bmin_q};
	assign band_mag  = band[THR_W-1] ? SAMPLE_W'(-band) : band[SAMPLE_W-1:0];
	assign band_prod = band_mag * RECIP_TEN;
	assign tenth     = THR_W'(band_prod[23:RECIP_SHIFT]);
	assign thresh    = {2'b00, bmin_q} + (band[THR_W-1] ? -tenth : tenth);

	// Lane result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= s1_move;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			lanes_s2  <= lane_res;
			batt_s2   <= batt_s1;
			blank_s2  <= blank_s1;
			thresh_s2 <= $signed(thresh);
		end
	end

	// Merge the lane results into the slot row.
	apm_merge #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_merge (
		.lanes (lanes_s2),
		.blank (blank_s2),
		.slots (merged)
	);

	// Slot emitter: loads a merged row and shifts out one slot per item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (s2_move) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (out_fire) begin
			if (cnt_last) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q + SW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s2_move) begin
			slots_q <= merged;
			low_q   <= $signed({2'b00, batt_s2}) <= thresh_s2;
			empty_q <= batt_s2 <= bmin_q;
		end else if (out_fire) begin
			for (int k = 0; k < SLOT_COUNT - 1; k++) begin
				slots_q[k] <= slots_q[k+1];
			end
		end
	end

	// Result ports.
	assign out_valid     = busy_q;
	assign slot_index    = IDX_W'(cnt_q);
	assign slot_value    = slots_q[0];
	assign battery_low   = low_q;
	assign battery_empty = empty_q;
	assign last          = cnt_last;

endmodule
